>>> hdl/stbs_pkg.sv
`timescale 1ns / 1ps

package stbs_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths of the result beat.
  localparam int INDEX_W = 10;
  localparam int STEPS_W = 4;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_STEP,
    B_FIN_HI,
    B_FIN_LO,
    B_RESULT
  } back_state_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    op_t                kind;
    logic signed [31:0] value;
  } cmd_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

>>> hdl/stbs_front.sv
`timescale 1ns / 1ps

module stbs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic signed [31:0]  value,
  input  stbs_pkg::q_flags_t  q_flags,
  output logic                push,
  output stbs_pkg::cmd_t      push_data
);
  import stbs_pkg::*;

  logic  held_valid;
  cmd_t  held;
  logic  accept;
  logic  keep;

  // The holding register takes a new beat when empty or when it drains now.
  assign push     = held_valid && !q_flags.full;
  assign in_ready = !held_valid || !q_flags.full;
  assign accept   = in_valid && in_ready;
  assign push_data = held;

  // Unused op codes are accepted and dropped here.
  always_comb begin
    unique case (op)
      OP_CLEAR, OP_APPEND, OP_SEARCH: keep = 1'b1;
      default:                        keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= keep;
    end else if (push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      held.kind  <= op_t'(op);
      held.value <= value;
    end
  end

endmodule

>>> hdl/stbs_queue.sv
`timescale 1ns / 1ps

module stbs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  stbs_pkg::cmd_t      push_data,
  input  logic                pop,
  output stbs_pkg::cmd_t      pop_data,
  output stbs_pkg::q_flags_t  q_flags
);
  import stbs_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign q_flags.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_flags.empty = (fill == '0);
  assign pop_data      = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hdl/stbs_back.sv
`timescale 1ns / 1ps

module stbs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  stbs_pkg::q_flags_t    q_flags,
  input  stbs_pkg::cmd_t        pop_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [9:0]            index,
  output logic [3:0]            steps
);
  import stbs_pkg::*;

  // Table storage and its registered read port.
  logic [31:0]        mem [TABLE_DEPTH];
  logic [31:0]        rdata;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;

  back_state_t        state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [ADDR_W-1:0]  lo, lo_next;
  logic [ADDR_W-1:0]  hi, hi_next;
  logic [ADDR_W-1:0]  mid, mid_next;
  logic [31:0]        key, key_next;
  logic [3:0]         steps_cnt, steps_next;
  status_t            res_status, res_status_next;
  logic [ADDR_W-1:0]  res_index, res_index_next;
  logic               load_out;

  logic [ADDR_W-1:0]  top_idx;
  logic [ADDR_W-1:0]  first_mid;
  logic               first_cont;
  logic               le;
  logic               eq;
  logic [ADDR_W-1:0]  step_lo;
  logic [ADDR_W-1:0]  step_hi;
  logic [ADDR_W:0]    step_sum;
  logic [ADDR_W-1:0]  step_mid;
  logic               step_cont;
  logic [3:0]         steps_inc;
  logic               out_free;

  // Shared search arithmetic.
  assign top_idx    = ADDR_W'(count - 1'b1);
  assign first_mid  = top_idx >> 1;
  assign first_cont = (count > COUNT_W'(2));
  assign le         = ($signed(rdata) <= $signed(key));
  assign eq         = (rdata == key);
  assign step_lo    = le ? mid : lo;
  assign step_hi    = le ? hi : mid - 1'b1;
  assign step_sum   = {1'b0, step_lo} + {1'b0, step_hi};
  assign step_mid   = step_sum[ADDR_W:1];
  assign step_cont  = ((step_hi - step_lo) > ADDR_W'(1));
  assign steps_inc  = (steps_cnt == 4'hF) ? steps_cnt : steps_cnt + 4'd1;
  assign out_free   = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_flags.empty && pop_data.kind == OP_SEARCH) begin
          if (count == '0) begin
            state_next = B_RESULT;
          end else if (first_cont) begin
            state_next = B_STEP;
          end else begin
            state_next = B_FIN_HI;
          end
        end
      end
      B_STEP:   state_next = step_cont ? B_STEP : B_FIN_HI;
      B_FIN_HI: state_next = eq ? B_RESULT : B_FIN_LO;
      B_FIN_LO: state_next = B_RESULT;
      B_RESULT: state_next = out_free ? B_IDLE : B_RESULT;
      default:  state_next = B_IDLE;
    endcase
  end

  // Datapath controls and next values.
  always_comb begin
    pop             = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = hi;
    load_out        = 1'b0;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    key_next        = key;
    steps_next      = steps_cnt;
    res_status_next = res_status;
    res_index_next  = res_index;
    unique case (state)
      B_IDLE: begin
        pop = !q_flags.empty;
        if (!q_flags.empty) begin
          unique case (pop_data.kind)
            OP_CLEAR: count_next = '0;
            OP_APPEND: begin
              if (count < COUNT_W'(TABLE_DEPTH)) begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_SEARCH: begin
              key_next   = pop_data.value;
              lo_next    = '0;
              hi_next    = top_idx;
              steps_next = '0;
              if (count == '0) begin
                res_status_next = ST_EMPTY;
                res_index_next  = '0;
              end else if (first_cont) begin
                rd_en      = 1'b1;
                rd_addr    = first_mid;
                mid_next   = first_mid;
                steps_next = 4'd1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = top_idx;
              end
            end
            default: ;
          endcase
        end
      end
      B_STEP: begin
        lo_next = step_lo;
        hi_next = step_hi;
        rd_en   = 1'b1;
        if (step_cont) begin
          rd_addr    = step_mid;
          mid_next   = step_mid;
          steps_next = steps_inc;
        end else begin
          rd_addr = step_hi;
        end
      end
      B_FIN_HI: begin
        if (eq) begin
          res_status_next = ST_FOUND;
          res_index_next  = hi;
        end else begin
          rd_en   = 1'b1;
          rd_addr = lo;
        end
      end
      B_FIN_LO: begin
        res_status_next = eq ? ST_FOUND : ST_NOT_FOUND;
        res_index_next  = eq ? lo : '0;
      end
      B_RESULT: load_out = out_free;
      default: ;
    endcase
  end

  // Table memory: one write or one read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[ADDR_W-1:0]] <= pop_data.value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search registers and the result beat.
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    key        <= key_next;
    steps_cnt  <= steps_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    if (load_out) begin
      status <= res_status;
      index  <= INDEX_W'(res_index);
      steps  <= steps_cnt;
    end
  end

endmodule

>>> hdl/sorted_table_binary_search_top.sv
// Sorted table with binary search.
// Input channel (in_valid/in_ready, op, value) takes one command per beat:
// op 0 clears the table, op 1 appends value at the next position (dropped
// when the table is full), op 2 searches for value; op 3 is dropped.
// Output channel (out_valid/out_ready, status, index, steps) carries one
// beat per search: found, not found or table empty, the matching position
// and the number of narrowing steps.
// A front register classifies each beat and feeds a two-entry command queue;
// the back engine drains it in order. Clear and append complete in idle.
// A search starts in idle, then takes its narrowing steps in turn (one table
// read each, about log2 of the entry count: 9 or 10 for 1024 entries), one
// or two final compares and the load of the output register; an empty
// table goes straight to that load. From acceptance, each command first
// passes the front register and a queue slot. The single table read port
// serializes the narrowing steps.
// Reset empties the queue and sets the entry count to zero; table contents
// are undefined until appended. A stalled receiver holds the result beat;
// the back engine then waits, while the queue takes commands until full.
`timescale 1ns / 1ps

module sorted_table_binary_search_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [9:0]         index,
  output logic [3:0]         steps
);
  import stbs_pkg::*;

  q_flags_t q_flags;
  logic     push;
  logic     pop;
  cmd_t     push_data;
  cmd_t     pop_data;

  stbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .value     (value),
    .q_flags   (q_flags),
    .push      (push),
    .push_data (push_data)
  );

  stbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_flags   (q_flags)
  );

  stbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_flags   (q_flags),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .index     (index),
    .steps     (steps)
  );

endmodule

>>> hdl/stbs_checker.sv
`timescale 1ns / 1ps

module stbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [9:0] index,
  input logic [3:0] steps
);
  import stbs_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({status, index, steps}))
    else $error("result beat changed while stalled");

  // An empty table reports no position and no steps.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> index == '0 && steps == '0)
    else $error("empty status with nonzero index or steps");

  // A miss reports position zero.
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOT_FOUND |-> index == '0)
    else $error("not found status with nonzero index");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .index     (index),
  .steps     (steps)
);
